### hdl/i2c_ee_pkg.sv
// types and constants for the i2c eeprom page access master
// no dependencies
package i2c_ee_pkg;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] start_address;
    logic [15:0] byte_count;
    logic [7:0]  write_byte;
    logic        sda_sample;
  } ee_in_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic [7:0] read_data;
    logic       read_valid;
    logic       byte_taken;
    logic       busy_res;
    logic       done_res;
    logic       success;
  } ee_out_t;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;

  localparam logic [1:0] CFG_DEV   = 2'd0;
  localparam logic [1:0] CFG_TWO   = 2'd1;
  localparam logic [1:0] CFG_TMO   = 2'd2;
  localparam logic [1:0] CFG_POLL  = 2'd3;

  localparam logic [6:0] DEV_RESET  = 7'h50;
  localparam logic [7:0] TMO_RESET  = 8'd250;
  localparam logic [9:0] POLL_RESET = 10'd1000;
  localparam logic [9:0] POLL_MAX   = 10'd1023;

endpackage

### hdl/i2c_eeprom_page_access_master.sv
// top level of the i2c eeprom page access master: state, config and output registers
// depends on i2c_ee_pkg and i2c_ee_step
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | ee_in_t (one bus tick)
//  out_    | output    | out_valid/out_stall| ee_out_t (one tick result)
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// one tick per clock while in_stall is low; the result of a tick is registered.
// the tick logic is a single combinational pass between state and result register.
// a skid register lets one more tick be accepted while out_stall is high.
// rst_n is synchronous, active low; it sets the sequencer idle and config to defaults.
module i2c_eeprom_page_access_master
  import i2c_ee_pkg::*;
#(
  parameter int PAGE_BYTES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  ee_in_t     in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output ee_out_t    out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_data
);

  logic [4:0]  ph_r, ph_nxt;
  logic [2:0]  tc_r, tc_nxt;
  logic [3:0]  bi_r, bi_nxt;
  logic [7:0]  sb_r, sb_nxt, aw_r, aw_nxt;
  logic [15:0] ca_r, ca_nxt, ba_r, ba_nxt, br_r, br_nxt;
  logic [9:0]  pc_r, pc_nxt;
  logic [6:0]  dev_r;
  logic        two_r;
  logic [7:0]  tmo_r;
  logic [9:0]  plim_r;
  ee_out_t     res;
  ee_out_t     out_r, skid_r;
  logic        ov_r, sv_r, acc;

  assign cfg_ready = 1'b1;
  assign in_stall  = sv_r;
  assign acc       = in_valid && !sv_r;
  assign out_valid = ov_r;
  assign out_data  = out_r;

  i2c_ee_step #(.PAGE_BYTES(PAGE_BYTES)) u_step (
    .ph_i(ph_r), .tc_i(tc_r), .bi_i(bi_r), .sb_i(sb_r), .ca_i(ca_r), .ba_i(ba_r),
    .br_i(br_r), .aw_i(aw_r), .pc_i(pc_r), .dev_i(dev_r), .two_i(two_r),
    .tmo_i(tmo_r), .plim_i(plim_r), .in_i(in_data),
    .ph_o(ph_nxt), .tc_o(tc_nxt), .bi_o(bi_nxt), .sb_o(sb_nxt), .ca_o(ca_nxt),
    .ba_o(ba_nxt), .br_o(br_nxt), .aw_o(aw_nxt), .pc_o(pc_nxt), .res_o(res)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_r <= DEV_RESET; two_r <= 1'b0; tmo_r <= TMO_RESET; plim_r <= POLL_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DEV:  dev_r  <= cfg_data[6:0];
        CFG_TWO:  two_r  <= cfg_data[0];
        CFG_TMO:  tmo_r  <= cfg_data[7:0];
        default:  plim_r <= cfg_data;
      endcase
    end
  end

  // sequencer state, advanced once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= '0; tc_r <= '0; bi_r <= '0; sb_r <= '0; ca_r <= '0; ba_r <= '0;
      br_r <= '0; aw_r <= '0; pc_r <= '0;
    end else if (acc) begin
      ph_r <= ph_nxt; tc_r <= tc_nxt; bi_r <= bi_nxt; sb_r <= sb_nxt;
      ca_r <= ca_nxt; ba_r <= ba_nxt; br_r <= br_nxt; aw_r <= aw_nxt;
      pc_r <= pc_nxt;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0; sv_r <= 1'b0;
    end else begin
      if (!ov_r || !out_stall) begin
        if (sv_r) begin
          out_r <= skid_r; ov_r <= 1'b1; sv_r <= 1'b0;
        end else begin
          out_r <= res; ov_r <= acc;
        end
      end else if (acc) begin
        skid_r <= res; sv_r <= 1'b1;
      end
    end
  end

endmodule

### hdl/i2c_ee_step.sv
// one bus tick of the eeprom sequencer: next state and result from current state
// depends on i2c_ee_pkg
module i2c_ee_step
  import i2c_ee_pkg::*;
#(
  parameter int PAGE_BYTES = 16
) (
  input  logic [4:0]  ph_i,
  input  logic [2:0]  tc_i,
  input  logic [3:0]  bi_i,
  input  logic [7:0]  sb_i,
  input  logic [15:0] ca_i,
  input  logic [15:0] ba_i,
  input  logic [15:0] br_i,
  input  logic [7:0]  aw_i,
  input  logic [9:0]  pc_i,
  input  logic [6:0]  dev_i,
  input  logic        two_i,
  input  logic [7:0]  tmo_i,
  input  logic [9:0]  plim_i,
  input  ee_in_t      in_i,
  output logic [4:0]  ph_o,
  output logic [2:0]  tc_o,
  output logic [3:0]  bi_o,
  output logic [7:0]  sb_o,
  output logic [15:0] ca_o,
  output logic [15:0] ba_o,
  output logic [15:0] br_o,
  output logic [7:0]  aw_o,
  output logic [9:0]  pc_o,
  output ee_out_t     res_o
);

  localparam int PW = $clog2(PAGE_BYTES);
  localparam logic [4:0]
    IDLE=0, W_STOP_PRE=1, PP_START=2, PP_DEV=3, PP_ACK=4, PP_STOP=5, W_AHI=6,
    W_AHI_ACK=7, W_ALO=8, W_ALO_ACK=9, W_DATA=10, W_DATA_ACK=11, FP_START=12,
    FP_DEV=13, FP_ACK=14, FP_STOP=15, FAIL_STOP=16, OK_STOP=17, R_START=18,
    R_DEV=19, R_DEV_ACK=20, R_AHI=21, R_AHI_ACK=22, R_ALO=23, R_ALO_ACK=24,
    R_RESTART=25, R_RDEV=26, R_RDEV_ACK=27, R_DATA=28, R_MACK=29;

  typedef enum logic [2:0] {K_START, K_STOP, K_SEND, K_ACK, K_READ, K_MACK} kind_t;

  logic [4:0]  p;
  kind_t       k;
  logic        fin, ok;
  logic [7:0]  ld, sh;
  logic [15:0] br_dec, ca_inc;
  logic [4:0]  nx;

  function automatic logic [7:0] dev_byte(input logic [6:0] d, input logic two,
                                          input logic [15:0] a);
    logic [7:0] b;
    b = {d, 1'b0};
    if (!two) b = b | {4'b0, a[10:8], 1'b0};
    return b;
  endfunction

  always_comb begin
    // command start on the accepting tick
    ph_o = ph_i; tc_o = tc_i; bi_o = bi_i; sb_o = sb_i; ca_o = ca_i; ba_o = ba_i;
    br_o = br_i; aw_o = aw_i; pc_o = pc_i;
    if (ph_i == IDLE && (in_i.action == ACT_READ || in_i.action == ACT_WRITE)) begin
      ca_o = in_i.start_address; ba_o = in_i.start_address; br_o = in_i.byte_count;
      aw_o = '0; pc_o = '0; sb_o = '0; tc_o = '0; bi_o = '0;
      ph_o = (in_i.action == ACT_READ) ? R_START : W_STOP_PRE;
    end
    p = ph_o;
    res_o = '0;
    res_o.scl_level = 1'b1; res_o.sda_level = 1'b1; res_o.sda_drive = 1'b1;
    fin = 1'b0; ok = 1'b1; ld = '0; sh = sb_o;
    // primitive kind
    unique case (p)
      PP_START, FP_START, R_START, R_RESTART: k = K_START;
      W_STOP_PRE, PP_STOP, FP_STOP, FAIL_STOP, OK_STOP: k = K_STOP;
      PP_ACK, W_AHI_ACK, W_ALO_ACK, W_DATA_ACK, FP_ACK, R_DEV_ACK, R_AHI_ACK,
      R_ALO_ACK, R_RDEV_ACK: k = K_ACK;
      R_DATA: k = K_READ;
      R_MACK: k = K_MACK;
      default: k = K_SEND;
    endcase
    // byte to send
    unique case (p)
      PP_DEV, R_DEV: ld = dev_byte(dev_i, two_i, ca_o);
      FP_DEV:        ld = dev_byte(dev_i, two_i, ba_o);
      W_AHI, R_AHI:  ld = ca_o[15:8];
      W_ALO, R_ALO:  ld = ca_o[7:0];
      R_RDEV:        ld = {dev_i, 1'b1};
      default:       ld = in_i.write_byte;
    endcase
    if (p != IDLE) begin
      unique case (k)
        K_START, K_STOP: begin
          res_o.scl_level = (tc_o != 3'd0);
          res_o.sda_level = (k == K_START) ? (tc_o != 3'd2) : (tc_o == 3'd2);
          if (tc_o >= 3'd2) fin = 1'b1; else tc_o = tc_o + 3'd1;
        end
        K_SEND: begin
          if (bi_o == 4'd0 && tc_o == 3'd0) begin
            sh = ld;
            res_o.byte_taken = (p == W_DATA);
          end
          res_o.sda_level = sh[7];
          if (tc_o == 3'd0) begin
            res_o.scl_level = 1'b0; tc_o = 3'd1;
          end else begin
            sh = {sh[6:0], 1'b0}; tc_o = 3'd0;
            if (bi_o >= 4'd7) fin = 1'b1; else bi_o = bi_o + 4'd1;
          end
          sb_o = sh;
        end
        K_ACK: begin
          res_o.sda_drive = 1'b0;
          if (tc_o == 3'd0) begin
            res_o.scl_level = 1'b0; aw_o = '0; tc_o = 3'd1;
          end else if (!in_i.sda_sample) fin = 1'b1;
          else if (aw_o >= tmo_i) begin
            fin = 1'b1; ok = 1'b0;
          end else aw_o = aw_o + 8'd1;
        end
        K_READ: begin
          res_o.sda_drive = 1'b0;
          if (tc_o == 3'd0) begin
            if (bi_o == 4'd0) sb_o = '0;
            res_o.scl_level = 1'b0; tc_o = 3'd1;
          end else begin
            sb_o = {sb_o[6:0], in_i.sda_sample}; tc_o = 3'd0;
            if (bi_o >= 4'd7) begin
              fin = 1'b1; res_o.read_data = sb_o; res_o.read_valid = 1'b1;
            end else bi_o = bi_o + 4'd1;
          end
        end
        default: begin
          res_o.sda_level = !(br_o > 16'd1);
          if (tc_o == 3'd0) begin
            res_o.scl_level = 1'b0; tc_o = 3'd1;
          end else fin = 1'b1;
        end
      endcase
    end
    // sequencing after a finished primitive
    br_dec = br_o - 16'd1;
    ca_inc = ca_o + 16'd1;
    nx = p + 5'd1;
    if (fin) begin
      unique case (p)
        W_STOP_PRE: begin
          pc_o = '0; nx = (br_o == 16'd0) ? FP_START : PP_START;
        end
        PP_ACK: begin
          if (ok) nx = two_i ? W_AHI : W_ALO;
          else begin
            if (pc_o < POLL_MAX) pc_o = pc_o + 10'd1;
            nx = PP_STOP;
          end
        end
        FP_ACK: begin
          if (ok) nx = OK_STOP;
          else begin
            if (pc_o < POLL_MAX) pc_o = pc_o + 10'd1;
            nx = FP_STOP;
          end
        end
        PP_STOP, FP_STOP: begin
          if (pc_o >= plim_i) begin
            nx = IDLE; res_o.done_res = 1'b1;
          end else nx = (p == PP_STOP) ? PP_START : FP_START;
        end
        FAIL_STOP: begin
          nx = IDLE; res_o.done_res = 1'b1;
        end
        OK_STOP: begin
          nx = IDLE; res_o.done_res = 1'b1; res_o.success = 1'b1;
        end
        W_AHI_ACK: nx = ok ? W_ALO : FAIL_STOP;
        W_ALO_ACK: nx = ok ? W_DATA : FAIL_STOP;
        W_DATA_ACK: begin
          if (!ok) nx = FAIL_STOP;
          else begin
            ca_o = ca_inc; br_o = br_dec;
            nx = (br_dec == 16'd0 || ca_inc[PW-1:0] == '0) ? W_STOP_PRE : W_DATA;
          end
        end
        R_DEV_ACK: nx = !ok ? FAIL_STOP : (two_i ? R_AHI : R_ALO);
        R_AHI_ACK: nx = ok ? R_ALO : FAIL_STOP;
        R_ALO_ACK: nx = ok ? R_RESTART : FAIL_STOP;
        R_RDEV_ACK: nx = !ok ? FAIL_STOP : ((br_o == 16'd0) ? OK_STOP : R_DATA);
        R_MACK: begin
          br_o = br_dec; nx = (br_dec == 16'd0) ? OK_STOP : R_DATA;
        end
        default: nx = p + 5'd1;
      endcase
      ph_o = nx; tc_o = '0; bi_o = '0;
    end
    res_o.busy_res = (ph_o != IDLE);
  end

endmodule

### hdl/i2c_ee_checker.sv
// port-level checks for the i2c eeprom page access master
// depends on i2c_ee_pkg; bound to the top level
module i2c_ee_checker
  import i2c_ee_pkg::*;
(
  input logic    clk,
  input logic    rst_n,
  input logic    out_valid,
  input logic    out_stall,
  input ee_out_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled transfer changed");
  a_succ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.success |-> out_data.done_res)
    else $error("success without done");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |-> !out_data.busy_res && out_data.scl_level)
    else $error("done while busy");
  a_rd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.read_valid |-> !out_data.sda_drive && out_data.busy_res)
    else $error("read byte while driving");

endmodule

bind i2c_eeprom_page_access_master i2c_ee_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
  .out_data(out_data)
);
